### rtl/npt_pkg.sv
package npt_pkg;

  localparam int SLOTS = 16;
  localparam int BUCKETS = 8;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int BKT_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int SCNT_W = $clog2(SLOTS + 1);

  localparam logic [1:0] CMD_ARM = 2'd0;
  localparam logic [1:0] CMD_TAKE = 2'd1;
  localparam logic [1:0] CMD_SWEEP = 2'd2;
  localparam logic [1:0] CMD_DARK = 2'd3;

  localparam logic [1:0] SLOT_FREE = 2'd0;
  localparam logic [1:0] SLOT_ARMED = 2'd1;
  localparam logic [1:0] SLOT_EXPIRED = 2'd2;

  localparam logic [2:0] ST_ARMED = 3'd0;
  localparam logic [2:0] ST_REJECT = 3'd1;
  localparam logic [2:0] ST_UNKNOWN = 3'd2;
  localparam logic [2:0] ST_INWIN = 3'd3;
  localparam logic [2:0] ST_LATE = 3'd4;
  localparam logic [2:0] ST_SWEPT = 3'd5;
  localparam logic [2:0] ST_DARK = 3'd6;

  localparam logic [1:0] REG_WAIT = 2'd0;
  localparam logic [1:0] REG_BUCKET = 2'd1;
  localparam logic [1:0] REG_MINSENT = 2'd2;
  localparam logic [1:0] REG_PERCENT = 2'd3;

  typedef struct packed {
    logic load;
    logic div_start;
    logic slot_clr;
    logic slot_step;
    logic bkt_clr;
    logic bkt_step;
    logic arm_commit;
    logic take_commit;
    logic bump_touch;
    logic dark_eval;
    logic out_load;
  } npt_cmd_t;

  typedef struct packed {
    logic [1:0] command;
    logic div_done;
    logic slot_last;
    logic bkt_last;
  } npt_sts_t;

endpackage

### rtl/npt_ctrl.sv
module npt_ctrl
  import npt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_fire,
  input  logic     out_busy,
  input  npt_sts_t sts,
  output npt_cmd_t cmd,
  output logic     idle
);

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_DIVW, S_SCAN, S_ACT, S_BKT, S_BUMP, S_DARK, S_OUT
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd.load = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_start = 1'b1;
        cmd.slot_clr = 1'b1;
        state_nxt = S_DIVW;
      end
      S_DIVW: begin
        if (sts.div_done) state_nxt = S_SCAN;
      end
      S_SCAN: begin
        cmd.slot_step = 1'b1;
        if (sts.slot_last) state_nxt = S_ACT;
      end
      S_ACT: begin
        if (sts.command == CMD_ARM) begin
          cmd.arm_commit = 1'b1;
          state_nxt = S_BUMP;
        end else if (sts.command == CMD_TAKE) begin
          cmd.take_commit = 1'b1;
          state_nxt = S_BUMP;
        end else if (sts.command == CMD_DARK) begin
          cmd.bkt_clr = 1'b1;
          state_nxt = S_BKT;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_BUMP: begin
        cmd.bump_touch = 1'b1;
        state_nxt = S_OUT;
      end
      S_BKT: begin
        cmd.bkt_step = 1'b1;
        if (sts.bkt_last) state_nxt = S_DARK;
      end
      S_DARK: begin
        cmd.dark_eval = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  assign idle = (state_r == S_IDLE);

endmodule

### rtl/npt_div.sv
module npt_div
  import npt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] num,
  input  logic [15:0] den,
  output logic [31:0] quo,
  output logic        done
);

  logic [31:0] q_r, q_nxt;
  logic [16:0] rem_r, rem_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [16:0] trial;
  logic [15:0] d;

  assign d = (den == 16'd0) ? 16'd1 : den;

  always_comb begin
    q_nxt = q_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    trial = {rem_r[15:0], q_r[31]};
    if (start) begin
      q_nxt = num;
      rem_nxt = '0;
      cnt_nxt = 6'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, d}) begin
        rem_nxt = trial - {1'b0, d};
        q_nxt = {q_r[30:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt = {q_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd31) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    rem_r <= rem_nxt;
  end

  assign quo = q_r;
  assign done = !busy_r && !start;

endmodule

### rtl/npt_dp.sv
module npt_dp
  import npt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  npt_cmd_t    cmd,
  output npt_sts_t    sts,
  input  logic [1:0]  in_command,
  input  logic [15:0] in_seq,
  input  logic [31:0] in_now_ms,
  input  logic [15:0] wait_ms,
  input  logic [15:0] bucket_ms,
  input  logic [15:0] dark_min_sent,
  input  logic [6:0]  dark_percent,
  output logic [2:0]  res_status,
  output logic [4:0]  res_expired,
  output logic        res_dark,
  output logic [31:0] rtt_last_r,
  output logic [31:0] rtt_max_r,
  output logic [31:0] cnt_sent_r,
  output logic [31:0] cnt_rec_r,
  output logic [31:0] cnt_late_r
);

  logic [1:0]  command_r;
  logic [15:0] seq_r;
  logic [31:0] now_r;
  logic [31:0] epoch;
  logic        div_done;

  npt_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(cmd.div_start),
    .num  (now_r),
    .den  (bucket_ms),
    .quo  (epoch),
    .done (div_done)
  );

  logic [15:0] slot_seq_r [SLOTS];
  logic [31:0] slot_dl_r [SLOTS];
  logic [31:0] slot_ep_r [SLOTS];
  logic [1:0]  slot_st_r [SLOTS];
  logic [31:0] bkt_ep_r [BUCKETS];
  logic        bkt_v_r [BUCKETS];
  logic [15:0] bkt_sent_r [BUCKETS];
  logic [15:0] bkt_rec_r [BUCKETS];
  logic        dark_lat_r;

  logic [SCNT_W-1:0] si_r;
  logic [SLOT_W-1:0] si;
  logic        hit_v_r, free_v_r, exp_v_r, any_arm_r;
  logic [SLOT_W-1:0] hit_r, free_r, exp_r;
  logic [4:0]  nexp_r;
  logic [2:0]  status_r;
  logic        dark_r;
  logic [BKT_W:0] bi_r;
  logic [BKT_W-1:0] bi;
  logic [31:0] sum_sent_r, sum_rec_r;
  logic        bump_rec_r;
  logic        bump_en_r;
  logic [31:0] bump_ep_r;

  assign si = si_r[SLOT_W-1:0];
  assign bi = bi_r[BKT_W-1:0];

  logic [31:0] sdiff, tdiff, rtt;
  logic [SLOT_W-1:0] tgt;
  logic        tgt_v;
  logic [31:0] ewin;

  assign sdiff = now_r - slot_dl_r[si];
  assign tgt_v = hit_v_r | free_v_r | exp_v_r;
  assign tgt = hit_v_r ? hit_r : (free_v_r ? free_r : exp_r);
  assign tdiff = now_r - slot_dl_r[hit_r];
  assign rtt = now_r - (slot_dl_r[hit_r] - {16'd0, wait_ms});
  assign ewin = epoch - bkt_ep_r[bi];

  assign sts.command = command_r;
  assign sts.div_done = div_done;
  assign sts.slot_last = (si_r == SCNT_W'(SLOTS - 1));
  assign sts.bkt_last = (bi_r == (BKT_W + 1)'(BUCKETS - 1));

  logic [38:0] lhs, rhs;
  assign lhs = 39'(sum_rec_r) * 39'd100;
  assign rhs = 39'(sum_sent_r) * 39'(dark_percent);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) slot_st_r[i] <= SLOT_FREE;
      for (int i = 0; i < BUCKETS; i++) bkt_v_r[i] <= 1'b0;
      dark_lat_r <= 1'b0;
      rtt_last_r <= '0;
      rtt_max_r <= '0;
      cnt_sent_r <= '0;
      cnt_rec_r <= '0;
      cnt_late_r <= '0;
      bump_en_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        command_r <= in_command;
        seq_r <= in_seq;
        now_r <= in_now_ms;
      end
      if (cmd.slot_clr) begin
        si_r <= '0;
        hit_v_r <= 1'b0;
        free_v_r <= 1'b0;
        exp_v_r <= 1'b0;
        any_arm_r <= 1'b0;
        nexp_r <= '0;
        bump_en_r <= 1'b0;
        status_r <= ST_SWEPT;
        dark_r <= 1'b0;
      end
      if (cmd.slot_step) begin
        si_r <= si_r + SCNT_W'(1);
        if (slot_st_r[si] != SLOT_FREE && slot_seq_r[si] == seq_r && !hit_v_r) begin
          hit_v_r <= 1'b1;
          hit_r <= si;
        end
        if (slot_st_r[si] == SLOT_FREE && !free_v_r) begin
          free_v_r <= 1'b1;
          free_r <= si;
        end
        if (slot_st_r[si] == SLOT_EXPIRED &&
            (!exp_v_r || slot_dl_r[si] < slot_dl_r[exp_r])) begin
          exp_v_r <= 1'b1;
          exp_r <= si;
        end
        if (slot_st_r[si] == SLOT_ARMED) any_arm_r <= 1'b1;
        if (command_r == CMD_SWEEP && slot_st_r[si] == SLOT_ARMED &&
            sdiff != 32'd0 && !sdiff[31]) begin
          slot_st_r[si] <= SLOT_EXPIRED;
          cnt_late_r <= cnt_late_r + 32'd1;
          nexp_r <= nexp_r + 5'd1;
        end
      end
      if (cmd.arm_commit) begin
        if (!tgt_v) begin
          status_r <= ST_REJECT;
        end else begin
          slot_seq_r[tgt] <= seq_r;
          slot_dl_r[tgt] <= now_r + {16'd0, wait_ms};
          slot_ep_r[tgt] <= epoch;
          slot_st_r[tgt] <= SLOT_ARMED;
          cnt_sent_r <= cnt_sent_r + 32'd1;
          status_r <= ST_ARMED;
          bump_en_r <= 1'b1;
          bump_rec_r <= 1'b0;
          bump_ep_r <= epoch;
        end
      end
      if (cmd.take_commit) begin
        if (!hit_v_r) begin
          status_r <= ST_UNKNOWN;
        end else begin
          slot_st_r[hit_r] <= SLOT_FREE;
          rtt_last_r <= rtt;
          if (rtt > rtt_max_r) rtt_max_r <= rtt;
          if (slot_st_r[hit_r] == SLOT_ARMED && (tdiff == 32'd0 || tdiff[31])) begin
            cnt_rec_r <= cnt_rec_r + 32'd1;
            status_r <= ST_INWIN;
            bump_en_r <= 1'b1;
            bump_rec_r <= 1'b1;
            bump_ep_r <= slot_ep_r[hit_r];
          end else begin
            if (slot_st_r[hit_r] == SLOT_ARMED) cnt_late_r <= cnt_late_r + 32'd1;
            status_r <= ST_LATE;
          end
        end
      end
      if (cmd.bump_touch && bump_en_r) begin
        logic [BKT_W-1:0] b;
        logic fresh;
        b = BKT_W'(bump_ep_r % BUCKETS);
        fresh = !bkt_v_r[b] || bkt_ep_r[b] != bump_ep_r;
        bkt_ep_r[b] <= bump_ep_r;
        bkt_v_r[b] <= 1'b1;
        if (bump_rec_r) begin
          bkt_sent_r[b] <= fresh ? 16'd0 : bkt_sent_r[b];
          bkt_rec_r[b] <= fresh ? 16'd1 :
                          (bkt_rec_r[b] == 16'hFFFF ? bkt_rec_r[b] : bkt_rec_r[b] + 16'd1);
        end else begin
          bkt_rec_r[b] <= fresh ? 16'd0 : bkt_rec_r[b];
          bkt_sent_r[b] <= fresh ? 16'd1 :
                           (bkt_sent_r[b] == 16'hFFFF ? bkt_sent_r[b] : bkt_sent_r[b] + 16'd1);
        end
      end
      if (cmd.bkt_clr) begin
        bi_r <= '0;
        sum_sent_r <= '0;
        sum_rec_r <= '0;
        status_r <= ST_DARK;
      end
      if (cmd.bkt_step) begin
        bi_r <= bi_r + (BKT_W + 1)'(1);
        if (bkt_v_r[bi] && ewin < 32'(BUCKETS)) begin
          sum_sent_r <= sum_sent_r + {16'd0, bkt_sent_r[bi]};
          sum_rec_r <= sum_rec_r + {16'd0, bkt_rec_r[bi]};
        end
      end
      if (cmd.dark_eval) begin
        if (dark_lat_r) begin
          dark_r <= 1'b1;
        end else if (!any_arm_r) begin
          if (sum_sent_r >= {16'd0, dark_min_sent} && lhs < rhs) begin
            dark_lat_r <= 1'b1;
            dark_r <= 1'b1;
          end
        end
      end
    end
  end

  assign res_status = status_r;
  assign res_expired = nexp_r;
  assign res_dark = dark_r;

endmodule

### rtl/nack_pending_tracker_core.sv
// Channel  Dir  tdata fields (low bit first)                  tuser
// in_      in   command[1:0], seq[17:2], now_ms[49:18]         none
// out_     out  status[2:0], expired_count[7:3], dark[8],      none
//               last rtt[40:9], max rtt[72:41], total_sent,
//               total_recovered, total_late
// cfg_     in   write enable, index, 16-bit data
// A command passes from its accepting edge through a setup step, the epoch divider,
// one scan step per slot and an action step, then one bucket update for arm and take,
// or one step per bucket plus one decision step for a dark query, before its result.
// Reset is synchronous and frees all slots and invalidates all buckets at once.
// The input is ready again when the result is loaded; a held result stalls the next
// command only when that command reaches its own output cycle.
module nack_pending_tracker_core
  import npt_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [55:0]  in_tdata,   // command, seq, now_ms
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [175:0] out_tdata,  // status, expired_count, dark, rtt last, rtt max, totals
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_data
);

  npt_cmd_t cmd;
  npt_sts_t sts;
  logic idle, in_fire;
  logic [15:0] wait_r, bkt_r, minsent_r;
  logic [6:0] pct_r;
  logic [2:0] st;
  logic [4:0] ex;
  logic dk;
  logic [31:0] rl, rm, cs, cr, cl;
  logic out_v_r;
  logic [175:0] out_d_r;

  assign in_tready = idle;
  assign in_fire = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wait_r <= 16'd100;
      bkt_r <= 16'd1000;
      minsent_r <= 16'd10;
      pct_r <= 7'd20;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WAIT: wait_r <= cfg_data;
        REG_BUCKET: bkt_r <= cfg_data;
        REG_MINSENT: minsent_r <= cfg_data;
        REG_PERCENT: pct_r <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  npt_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire),
    .out_busy(out_v_r && !out_tready), .sts(sts), .cmd(cmd), .idle(idle)
  );

  npt_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_command(in_tdata[1:0]), .in_seq(in_tdata[17:2]), .in_now_ms(in_tdata[49:18]),
    .wait_ms(wait_r), .bucket_ms(bkt_r), .dark_min_sent(minsent_r), .dark_percent(pct_r),
    .res_status(st), .res_expired(ex), .res_dark(dk),
    .rtt_last_r(rl), .rtt_max_r(rm), .cnt_sent_r(cs), .cnt_rec_r(cr), .cnt_late_r(cl)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      if (cmd.out_load) out_v_r <= 1'b1;
      else if (out_tready) out_v_r <= 1'b0;
    end
    if (cmd.out_load) out_d_r <= {7'd0, cl, cr, cs, rm, rl, dk, ex, st};
  end

  assign out_tvalid = out_v_r;
  assign out_tdata = out_d_r;

`ifndef NO_ASSERTIONS
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !(out_v_r && !out_tready)) else $error("result overwritten");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_tready) else $error("accepted while busy");
`endif

endmodule

### bench/nack_pending_tracker_core_tb.sv
`timescale 1ns / 1ps

module nack_pending_tracker_core_tb
  import npt_pkg::*;
();

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [55:0]  in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [175:0] out_tdata;
  logic         cfg_we = 1'b0;
  logic [1:0]   cfg_index = '0;
  logic [15:0]  cfg_data = '0;

  typedef struct packed {
    logic [31:0] late;
    logic [31:0] recovered;
    logic [31:0] sent;
    logic [31:0] rtt_max;
    logic [31:0] rtt_last;
    logic        dark;
    logic [4:0]  expired;
    logic [2:0]  status;
  } tracker_result_t;

  nack_pending_tracker_core dut (.*);

  always #4 clk = ~clk;

  logic [15:0] wait_reg, bucket_reg, minsent_reg;
  logic [6:0]  percent_reg;
  logic [15:0] s_seq [SLOTS];
  logic [31:0] s_deadline [SLOTS];
  logic [31:0] s_epoch [SLOTS];
  logic [1:0]  s_status [SLOTS];
  logic [31:0] b_epoch [BUCKETS];
  logic        b_valid [BUCKETS];
  logic [15:0] b_sent [BUCKETS];
  logic [15:0] b_rec [BUCKETS];
  logic        dark_flag;
  logic [31:0] rtt_last_q, rtt_max_q, sent_q, rec_q, late_q;

  tracker_result_t expected_words [$];
  int errors = 0;
  int idle_cycles = 0;
  logic [15:0] seq_pool [8];

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    errors++;
  endtask

  function automatic logic [31:0] epoch_of(input logic [31:0] now);
    return now / ((bucket_reg == 0) ? 32'd1 : {16'd0, bucket_reg});
  endfunction

  function automatic int touch_bucket(input logic [31:0] ep);
    int b;
    b = ep % BUCKETS;
    if (!b_valid[b] || b_epoch[b] != ep) begin
      b_epoch[b] = ep;
      b_valid[b] = 1'b1;
      b_sent[b] = 0;
      b_rec[b] = 0;
    end
    return b;
  endfunction

  function automatic int find_seq(input logic [15:0] seq);
    for (int i = 0; i < SLOTS; i++)
      if (s_status[i] != SLOT_FREE && s_seq[i] == seq) return i;
    return -1;
  endfunction

  function automatic void clear_tracker();
    wait_reg = 100; bucket_reg = 1000; minsent_reg = 10; percent_reg = 20;
    for (int i = 0; i < SLOTS; i++) begin
      s_seq[i] = 0; s_deadline[i] = 0; s_epoch[i] = 0; s_status[i] = SLOT_FREE;
    end
    for (int i = 0; i < BUCKETS; i++) begin
      b_epoch[i] = 0; b_valid[i] = 0; b_sent[i] = 0; b_rec[i] = 0;
    end
    dark_flag = 0;
    rtt_last_q = 0; rtt_max_q = 0; sent_q = 0; rec_q = 0; late_q = 0;
  endfunction

  function automatic tracker_result_t track_command(input logic [1:0] cmd,
      input logic [15:0] seq, input logic [31:0] now);
    tracker_result_t r;
    int s, b;
    logic [31:0] rtt, diff, ne;
    logic [1:0] was;
    logic any_armed;
    logic [63:0] sent, rec;
    r = '0;
    case (cmd)
      CMD_ARM: begin
        s = find_seq(seq);
        if (s < 0) begin
          for (int i = 0; i < SLOTS && s < 0; i++)
            if (s_status[i] == SLOT_FREE) s = i;
          if (s < 0)
            for (int i = 0; i < SLOTS; i++)
              if (s_status[i] == SLOT_EXPIRED && (s < 0 || s_deadline[i] < s_deadline[s]))
                s = i;
        end
        if (s < 0) begin
          r.status = ST_REJECT;
        end else begin
          s_seq[s] = seq;
          s_deadline[s] = now + wait_reg;
          s_epoch[s] = epoch_of(now);
          s_status[s] = SLOT_ARMED;
          b = touch_bucket(epoch_of(now));
          if (b_sent[b] != 16'hFFFF) b_sent[b]++;
          sent_q++;
          r.status = ST_ARMED;
        end
      end
      CMD_TAKE: begin
        s = find_seq(seq);
        if (s < 0) begin
          r.status = ST_UNKNOWN;
        end else begin
          was = s_status[s];
          rtt = now - (s_deadline[s] - wait_reg);
          diff = now - s_deadline[s];
          s_status[s] = SLOT_FREE;
          rtt_last_q = rtt;
          if (rtt > rtt_max_q) rtt_max_q = rtt;
          if (was == SLOT_ARMED && (diff == 0 || diff[31])) begin
            b = touch_bucket(s_epoch[s]);
            if (b_rec[b] != 16'hFFFF) b_rec[b]++;
            rec_q++;
            r.status = ST_INWIN;
          end else begin
            if (was == SLOT_ARMED) late_q++;
            r.status = ST_LATE;
          end
        end
      end
      CMD_SWEEP: begin
        for (int i = 0; i < SLOTS; i++) begin
          diff = now - s_deadline[i];
          if (s_status[i] == SLOT_ARMED && diff != 0 && !diff[31]) begin
            s_status[i] = SLOT_EXPIRED;
            late_q++;
            r.expired++;
          end
        end
        r.status = ST_SWEPT;
      end
      default: begin
        r.status = ST_DARK;
        if (dark_flag) begin
          r.dark = 1;
        end else begin
          any_armed = 0;
          for (int i = 0; i < SLOTS; i++)
            if (s_status[i] == SLOT_ARMED) any_armed = 1;
          if (!any_armed) begin
            ne = epoch_of(now);
            sent = 0; rec = 0;
            for (int i = 0; i < BUCKETS; i++)
              if (b_valid[i] && (ne - b_epoch[i]) < BUCKETS) begin
                sent += b_sent[i];
                rec += b_rec[i];
              end
            if (sent >= minsent_reg && rec * 100 < sent * percent_reg) dark_flag = 1;
            r.dark = dark_flag;
          end
        end
      end
    endcase
    r.rtt_last = rtt_last_q; r.rtt_max = rtt_max_q;
    r.sent = sent_q; r.recovered = rec_q; r.late = late_q;
    return r;
  endfunction

  task automatic send_word(input logic [1:0] cmd, input logic [15:0] seq,
      input logic [31:0] now);
    int gap;
    gap = $urandom_range(0, 7);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {6'd0, now, seq, cmd};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_words.push_back(track_command(cmd, seq, now));
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_WAIT: wait_reg = val;
      REG_BUCKET: bucket_reg = val;
      REG_MINSENT: minsent_reg = val;
      default: percent_reg = val[6:0];
    endcase
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    tracker_result_t got, want;
    if (out_tvalid && out_tready) begin
      got = out_tdata[168:0];
      if (expected_words.size() == 0) begin
        report("unexpected word", 32'(got.status), 32'd0);
      end else begin
        want = expected_words.pop_front();
        if (got.status != want.status)
          report("status", 32'(got.status), 32'(want.status));
        if (got.expired != want.expired)
          report("expired_count", 32'(got.expired), 32'(want.expired));
        if (got.dark != want.dark) report("dark", 32'(got.dark), 32'(want.dark));
        if (got.rtt_last != want.rtt_last) report("last_rtt", got.rtt_last, want.rtt_last);
        if (got.rtt_max != want.rtt_max) report("max_rtt", got.rtt_max, want.rtt_max);
        if (got.sent != want.sent) report("total_sent", got.sent, want.sent);
        if (got.recovered != want.recovered)
          report("total_recovered", got.recovered, want.recovered);
        if (got.late != want.late) report("total_late", got.late, want.late);
      end
    end
  end

  int stall_left = 0;
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (!out_tready || out_tvalid) begin
      if ($urandom_range(0, 2) == 0) begin
        stall_left <= $urandom_range(0, 6);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("nack_pending_tracker_core_tb: errors");
      $finish;
    end
  end

  task automatic test_directed();
    send_word(CMD_DARK, 16'h0000, 32'd0);
    send_word(CMD_TAKE, 16'hFFFF, 32'd5);
    send_word(CMD_ARM, 16'hFFFF, 32'hFFFF_FFF0);
    send_word(CMD_ARM, 16'h0000, 32'd0);
    send_word(CMD_ARM, 16'hFFFF, 32'hFFFF_FFF8);
    send_word(CMD_SWEEP, 16'h1234, 32'd100);
    send_word(CMD_SWEEP, 16'h1234, 32'd101);
    send_word(CMD_TAKE, 16'h0000, 32'd150);
    send_word(CMD_TAKE, 16'hFFFF, 32'h0000_005C);
    for (int i = 0; i < SLOTS + 1; i++)
      send_word(CMD_ARM, 16'(16'h100 + i), 32'(1000 + i));
    send_word(CMD_SWEEP, 16'h0, 32'd5000);
    send_word(CMD_ARM, 16'h0200, 32'd6000);
    send_word(CMD_DARK, 16'h0, 32'd6000);
  endtask

  task automatic test_dark_latch();
    write_reg(REG_BUCKET, 16'd0);
    write_reg(REG_MINSENT, 16'd2);
    write_reg(REG_PERCENT, 16'd100);
    for (int i = 0; i < SLOTS; i++) send_word(CMD_TAKE, 16'(16'h100 + i), 32'd7000);
    send_word(CMD_TAKE, 16'h0200, 32'd7000);
    send_word(CMD_ARM, 16'h0300, 32'd7000);
    send_word(CMD_ARM, 16'h0301, 32'd7001);
    send_word(CMD_TAKE, 16'h0300, 32'd7002);
    send_word(CMD_SWEEP, 16'h0, 32'd9000);
    send_word(CMD_DARK, 16'h0, 32'd9001);
    send_word(CMD_DARK, 16'h0, 32'hFFFF_FFFF);
    drain();
  endtask

  task automatic test_random(input int count);
    logic [31:0] now;
    logic [1:0] cmd;
    logic [15:0] seq;
    now = $urandom;
    for (int i = 0; i < 8; i++) seq_pool[i] = 16'($urandom);
    for (int n = 0; n < count; n++) begin
      now += $urandom_range(0, 3 * wait_reg + 4);
      if ($urandom_range(0, 9) == 0) now = $urandom;
      case ($urandom_range(0, 9))
        0, 1, 2, 3: cmd = CMD_ARM;
        4, 5, 6: cmd = CMD_TAKE;
        7, 8: cmd = CMD_SWEEP;
        default: cmd = CMD_DARK;
      endcase
      seq = ($urandom_range(0, 5) == 0) ? 16'($urandom) : seq_pool[$urandom_range(0, 7)];
      if ($urandom_range(0, 40) == 0) seq_pool[$urandom_range(0, 7)] = 16'($urandom);
      send_word(cmd, seq, now);
    end
  endtask

  task automatic test_settings();
    write_reg(REG_WAIT, 16'd1);
    write_reg(REG_BUCKET, 16'd1);
    write_reg(REG_MINSENT, 16'd0);
    write_reg(REG_PERCENT, 16'd0);
    test_random(157);
    drain();
    write_reg(REG_WAIT, 16'hFFFF);
    write_reg(REG_BUCKET, 16'hFFFF);
    write_reg(REG_MINSENT, 16'hFFFF);
    write_reg(REG_PERCENT, 16'd127);
    test_random(157);
    drain();
    for (int k = 0; k < 5; k++) begin
      write_reg(REG_WAIT, 16'($urandom_range(1, 400)));
      write_reg(REG_BUCKET, 16'($urandom_range(1, 2000)));
      write_reg(REG_MINSENT, 16'($urandom_range(0, 20)));
      write_reg(REG_PERCENT, 16'($urandom_range(0, 100)));
      test_random(157);
      drain();
    end
  endtask

  initial begin
    clear_tracker();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    drain();
    test_dark_latch();
    test_settings();
    drain();
    if (errors == 0) begin
      $display("nack_pending_tracker_core_tb: clean");
    end else begin
      $display("nack_pending_tracker_core_tb: errors");
    end
    $finish;
  end

endmodule
